// ----- sv/lpbe_pkg.sv -----
// ---------------------------------------------------------------------------
// lpbe_pkg
// shared types and constants of the led pixel bit encoder
// ---------------------------------------------------------------------------
`default_nettype none

package lpbe_pkg;

  // tick counters and timing registers
  localparam int unsigned TickWidth = 15;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  // pixel queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // symbol counter, counts down to the last symbol of a pixel
  localparam int unsigned SymCntW = 5;
  localparam logic [SymCntW-1:0] LastSym3 = SymCntW'(24 - 1);
  localparam logic [SymCntW-1:0] LastSym4 = SymCntW'(32 - 1);

  typedef logic [TickWidth-1:0] tick_t;

  typedef enum logic [1:0] {
    OrderRgb  = 2'd0,
    OrderGrb  = 2'd1,
    OrderRgbw = 2'd2,
    OrderWrgb = 2'd3
  } color_order_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegColorOrder = 3'd0,
    RegZeroHigh   = 3'd1,
    RegZeroLow    = 3'd2,
    RegOneHigh    = 3'd3,
    RegOneLow     = 3'd4
  } reg_idx_e;

  // reset values of the registers
  localparam color_order_e ColorOrderRst = OrderGrb;
  localparam tick_t ZeroHighRst = TickWidth'(3);
  localparam tick_t ZeroLowRst  = TickWidth'(9);
  localparam tick_t OneHighRst  = TickWidth'(9);
  localparam tick_t OneLowRst   = TickWidth'(3);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    tick_t high_ticks;
    tick_t low_ticks;
    logic  bit_value;
    logic  pixel_done;
    logic  frame_done;
  } symbol_t;

  typedef struct packed {
    tick_t zero_high;
    tick_t zero_low;
    tick_t one_high;
    tick_t one_low;
  } timing_t;

  // one classified pixel: reordered bytes, first byte highest
  typedef struct packed {
    logic [31:0] bits;
    logic        four_byte;
    logic        last_pixel;
  } entry_t;

endpackage

`default_nettype wire

// ----- sv/lpbe_front.sv -----
// ---------------------------------------------------------------------------
// lpbe_front
// accepts pixels and reorders their bytes by the colour order
// ---------------------------------------------------------------------------
`default_nettype none

module lpbe_front import lpbe_pkg::*; (
  input  wire color_order_e color_order_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire pixel_t       in_data_i,
  input  wire               q_ready_i,
  output logic              q_push_o,
  output entry_t            q_entry_o
);

  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i & q_ready_i;

  always_comb begin
    q_entry_o.last_pixel = in_data_i.last_pixel;
    case (color_order_i)
      OrderRgb: begin
        q_entry_o.bits      = {in_data_i.red, in_data_i.green, in_data_i.blue, 8'h00};
        q_entry_o.four_byte = 1'b0;
      end
      OrderGrb: begin
        q_entry_o.bits      = {in_data_i.green, in_data_i.red, in_data_i.blue, 8'h00};
        q_entry_o.four_byte = 1'b0;
      end
      OrderRgbw: begin
        q_entry_o.bits      = {in_data_i.red, in_data_i.green, in_data_i.blue,
                               in_data_i.white};
        q_entry_o.four_byte = 1'b1;
      end
      default: begin
        q_entry_o.bits      = {in_data_i.white, in_data_i.red, in_data_i.green,
                               in_data_i.blue};
        q_entry_o.four_byte = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/lpbe_fifo.sv -----
// ---------------------------------------------------------------------------
// lpbe_fifo
// short pixel queue between the front and the symbol shifter
// ---------------------------------------------------------------------------
`default_nettype none

module lpbe_fifo import lpbe_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push_i,
  input  wire entry_t push_data_i,
  output logic        ready_o,
  input  wire         pop_i,
  output logic        valid_o,
  output entry_t      pop_data_o
);

  entry_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   count_q, count_d;
  logic                  do_push, do_pop;

  assign ready_o    = (count_q != FifoCntW'(FifoDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth))
    else $error("pixel queue over capacity");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FifoCntW'(FifoDepth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pixel queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ----- sv/lpbe_back.sv -----
// ---------------------------------------------------------------------------
// lpbe_back
// shifts out one pulse symbol per cycle to the output register unless stalled
// ---------------------------------------------------------------------------
`default_nettype none

module lpbe_back import lpbe_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire timing_t timing_i,
  input  wire          q_valid_i,
  input  wire entry_t  q_entry_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output symbol_t      out_data_o
);

  logic                cur_valid_q;
  logic [31:0]         shift_q;
  logic [SymCntW-1:0]  cnt_q;
  logic                last_q;
  logic                out_valid_q;
  symbol_t             out_q;
  logic                adv, cur_end, cur_bit;

  assign adv     = cur_valid_q & (~out_valid_q | out_ready_i);
  assign cur_end = (cnt_q == '0);
  assign cur_bit = shift_q[31];
  assign q_pop_o = q_valid_i & (~cur_valid_q | (adv & cur_end));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cur_valid_q <= 1'b1;
      end else if (adv && cur_end) begin
        cur_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      shift_q <= q_entry_i.bits;
      cnt_q   <= q_entry_i.four_byte ? LastSym4 : LastSym3;
      last_q  <= q_entry_i.last_pixel;
    end else if (adv) begin
      shift_q <= {shift_q[30:0], 1'b0};
      cnt_q   <= cnt_q - 1'b1;
    end
    if (adv) begin
      out_q.high_ticks <= cur_bit ? timing_i.one_high : timing_i.zero_high;
      out_q.low_ticks  <= cur_bit ? timing_i.one_low : timing_i.zero_low;
      out_q.bit_value  <= cur_bit;
      out_q.pixel_done <= cur_end;
      out_q.frame_done <= cur_end & last_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_frame_in_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_done) |-> out_q.pixel_done)
    else $error("frame end outside a pixel end");

  a_pixel_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && cur_end) |=> (out_valid_q && out_q.pixel_done))
    else $error("pixel end symbol missing");

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (!cur_valid_q || (adv && cur_end)))
    else $error("pixel loaded over a pixel in progress");
`endif

endmodule

`default_nettype wire

// ----- sv/led_pixel_bit_encoder_unit.sv -----
// ---------------------------------------------------------------------------
// led_pixel_bit_encoder_unit
// pulse symbol encoder for serial rgb(w) led strips
// ---------------------------------------------------------------------------
// usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one pixel word:
//   red, green, blue, white and a last-pixel mark
//   out channel (out_valid_o/out_ready_i/out_data_o) gives one word per
//   data bit, msb first: high and low durations in ticks, the bit, a
//   pixel end mark and a frame end mark
//   rgb and grb send 24 symbols per pixel, rgbw and wrgb send 32
// path: a pixel taken while the shifter is free passes the queue, the
//   shifter and the output register before its first symbol is valid
// throughput: one symbol per cycle while out_ready_i is high, set by the
//   single-bit shifter in the back end; a two-entry queue lets the next
//   pixels wait while the current one is shifted out
// stall: a held out_ready_i freezes the output register and the shifter;
//   pixels keep being taken until the queue fills
// reset: queue and shifter empty, registers at grb, 3/9 and 9/3 ticks
// config: write registers only while no pixel is in flight
// ---------------------------------------------------------------------------
`default_nettype none

module led_pixel_bit_encoder_unit import lpbe_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  // configuration write port
  input  wire                cfg_we_i,
  input  wire [CfgIdxW-1:0]  cfg_idx_i,
  input  wire [CfgDataW-1:0] cfg_wdata_i,
  // pixel input
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire pixel_t        in_data_i,
  // symbol output
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output symbol_t            out_data_o
);

  color_order_e color_order_q;
  timing_t      timing_q;

  // front to queue
  logic   q_ready, q_push;
  entry_t q_push_entry;
  // queue to back
  logic   q_valid, q_pop;
  entry_t q_pop_entry;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_order_q      <= ColorOrderRst;
      timing_q.zero_high <= ZeroHighRst;
      timing_q.zero_low  <= ZeroLowRst;
      timing_q.one_high  <= OneHighRst;
      timing_q.one_low   <= OneLowRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegColorOrder: color_order_q      <= color_order_e'(cfg_wdata_i[1:0]);
        RegZeroHigh:   timing_q.zero_high <= tick_t'(cfg_wdata_i);
        RegZeroLow:    timing_q.zero_low  <= tick_t'(cfg_wdata_i);
        RegOneHigh:    timing_q.one_high  <= tick_t'(cfg_wdata_i);
        RegOneLow:     timing_q.one_low   <= tick_t'(cfg_wdata_i);
        default: ;     // indexes past the list are dropped
      endcase
    end
  end

  // byte reorder and accept
  lpbe_front u_front (
    .color_order_i (color_order_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_entry_o     (q_push_entry)
  );

  // pixel queue
  lpbe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_entry),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_pop_entry)
  );

  // symbol shifter and output register
  lpbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timing_i    (timing_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- sim/lpbe_symbol_checker.sv -----
// ---------------------------------------------------------------------------
// lpbe_symbol_checker
// watches the config port and both word channels of the led pixel bit
// encoder, predicts the symbol words of every pixel taken and compares
// them field by field in order of arrival
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module lpbe_symbol_checker import lpbe_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire [CfgIdxW-1:0]  cfg_idx_i,
  input  wire [CfgDataW-1:0] cfg_wdata_i,
  input  wire                in_valid_i,
  input  wire                in_ready_i,
  input  pixel_t             in_data_i,
  input  wire                out_valid_i,
  input  wire                out_ready_i,
  input  symbol_t            out_data_i,
  output int unsigned        mismatch_cnt_o,
  output int unsigned        symbols_due_o
);

  // mirrored registers
  color_order_e order_q;
  tick_t        zero_high_q;
  tick_t        zero_low_q;
  tick_t        one_high_q;
  tick_t        one_low_q;

  symbol_t symbols_due[$];

  initial mismatch_cnt_o = 0;

  // one symbol word per sent bit, first byte msb first
  task automatic queue_pixel_symbols(input pixel_t px);
    logic [31:0] bytes;
    int unsigned nsym;
    int unsigned k;
    symbol_t     sym;
    case (order_q)
      OrderRgb: begin
        bytes = {px.red, px.green, px.blue, 8'h00};
        nsym  = 24;
      end
      OrderGrb: begin
        bytes = {px.green, px.red, px.blue, 8'h00};
        nsym  = 24;
      end
      OrderRgbw: begin
        bytes = {px.red, px.green, px.blue, px.white};
        nsym  = 32;
      end
      default: begin
        bytes = {px.white, px.red, px.green, px.blue};
        nsym  = 32;
      end
    endcase
    for (k = 0; k < nsym; k++) begin
      sym.bit_value  = bytes[31 - k];
      sym.high_ticks = sym.bit_value ? one_high_q : zero_high_q;
      sym.low_ticks  = sym.bit_value ? one_low_q : zero_low_q;
      sym.pixel_done = (k == nsym - 1);
      sym.frame_done = sym.pixel_done & px.last_pixel;
      symbols_due.push_back(sym);
    end
  endtask

  task automatic check_field(input string name, input tick_t want, input tick_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt_o++;
    end
  endtask

  task automatic check_symbol(input symbol_t got);
    symbol_t want;
    if (symbols_due.size() == 0) begin
      $error("symbol word with nothing pending: %h", got);
      mismatch_cnt_o++;
    end else begin
      want = symbols_due.pop_front();
      check_field("high_ticks", want.high_ticks, got.high_ticks);
      check_field("low_ticks", want.low_ticks, got.low_ticks);
      check_field("bit_value", tick_t'(want.bit_value), tick_t'(got.bit_value));
      check_field("pixel_done", tick_t'(want.pixel_done), tick_t'(got.pixel_done));
      check_field("frame_done", tick_t'(want.frame_done), tick_t'(got.frame_done));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q       = ColorOrderRst;
      zero_high_q   = ZeroHighRst;
      zero_low_q    = ZeroLowRst;
      one_high_q    = OneHighRst;
      one_low_q     = OneLowRst;
      symbols_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegColorOrder: order_q     = color_order_e'(cfg_wdata_i[1:0]);
          RegZeroHigh:   zero_high_q = cfg_wdata_i[TickWidth-1:0];
          RegZeroLow:    zero_low_q  = cfg_wdata_i[TickWidth-1:0];
          RegOneHigh:    one_high_q  = cfg_wdata_i[TickWidth-1:0];
          RegOneLow:     one_low_q   = cfg_wdata_i[TickWidth-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) queue_pixel_symbols(in_data_i);
      if (out_valid_i && out_ready_i) check_symbol(out_data_i);
      symbols_due_o <= symbols_due.size();
    end
  end

endmodule

// ----- sim/led_pixel_bit_encoder_unit_test.sv -----
// ---------------------------------------------------------------------------
// led_pixel_bit_encoder_unit_test
// drives pixel words into the led pixel bit encoder under a series of
// color orders and pulse timings, stalls the symbol side, and leaves the
// checking to lpbe_symbol_checker; prints the verdict at the end
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module led_pixel_bit_encoder_unit_test;
  import lpbe_pkg::*;

  // register indexes past the end of the map, writes there must do nothing
  localparam logic [CfgIdxW-1:0] FirstUnusedIdx = 3'd5;
  localparam logic [CfgIdxW-1:0] LastUnusedIdx  = 3'd7;

  localparam int unsigned RandomItems  = 80;
  localparam int unsigned HoldOffLen   = 200;  // long receiver hold-off
  localparam int unsigned DrainSettle  = 8;    // settle time after the drain
  localparam int unsigned EndSettle    = 40;
  localparam int unsigned StallLimit   = 2000; // cycles without any word moving

  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyCoin,
    ReadyMostly,
    ReadyRarely
  } ready_mode_e;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  pixel_t              in_data;
  logic                out_valid;
  logic                out_ready;
  symbol_t             out_data;

  int unsigned mismatch_cnt;
  int unsigned symbols_due;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned hold_off_req;
  int unsigned hold_off_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  led_pixel_bit_encoder_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  lpbe_symbol_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .mismatch_cnt_o(mismatch_cnt),
    .symbols_due_o (symbols_due)
  );

  // watchdog: any stretch with no word moving on either side is a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("** led_pixel_bit_encoder_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // symbol receiver: stall patterns of its own, changing after random spans,
  // plus a long hold-off on request so the pixel queue fills up
  initial begin
    ready_mode_e mode;
    int unsigned span;
    out_ready <= 1'b0;
    forever begin
      if (hold_off_done != hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk);
        hold_off_done++;
      end else begin
        mode = ready_mode_e'($urandom_range(0, 3));
        span = $urandom_range(4, 40);
        repeat (span) begin
          case (mode)
            ReadyAlways: out_ready <= 1'b1;
            ReadyCoin:   out_ready <= $urandom_range(0, 1);
            ReadyMostly: out_ready <= ($urandom_range(0, 3) != 0);
            default:     out_ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // offer one pixel word and hold it until taken; gaps come between bursts
  task automatic send_pixel(input pixel_t px);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                      input logic [7:0] w, input logic last);
    pixel_t px;
    px = '{red: r, green: g, blue: b, white: w, last_pixel: last};
    send_pixel(px);
  endtask

  // stop offering and wait until every predicted symbol word is out;
  // sampled on the falling edge so the checker's count has settled
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (symbols_due != 0);
    repeat (DrainSettle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // full register set, plus one write to an index past the map;
  // spare data bits above the order field carry random junk
  task automatic configure(input color_order_e order, input tick_t zh, input tick_t zl,
                           input tick_t oh, input tick_t ol);
    logic [CfgDataW-1:0] order_word;
    order_word      = CfgDataW'($urandom());
    order_word[1:0] = order;
    write_reg(RegColorOrder, order_word);
    write_reg(RegZeroHigh, zh);
    write_reg(RegZeroLow, zl);
    write_reg(RegOneHigh, oh);
    write_reg(RegOneLow, ol);
    write_reg(CfgIdxW'($urandom_range(FirstUnusedIdx, LastUnusedIdx)), CfgDataW'($urandom()));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic tick_t random_duration();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return tick_t'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_items;
    int unsigned frame_left;
    pixel_t      px;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    idle_cycles  = 0;
    burst_left   = 0;
    hold_off_req = 0;
    hold_off_done = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: grb, 3/9 and 9/3; white is ignored here
    send(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1);
    send(8'hA5, 8'h3C, 8'h0F, 8'hFF, 1'b0);
    send(8'h80, 8'h01, 8'h7E, 8'h55, 1'b1);
    wait_drained();

    // rgbw with zero durations on zero bits and widest on one bits
    configure(OrderRgbw, '0, '0, '1, '1);
    send(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
    send(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
    send(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
    send(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1);
    wait_drained();

    // wrgb, the other way round
    configure(OrderWrgb, '1, tick_t'(1), '0, tick_t'(15'h7FFE));
    send(8'h01, 8'h02, 8'h04, 8'h80, 1'b0);
    send(8'hFE, 8'hFD, 8'hFB, 8'h7F, 1'b0);
    send(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
    send(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    wait_drained();

    // rgb: a full white byte must not show up
    configure(OrderRgb, tick_t'(1), tick_t'(2), tick_t'(4), tick_t'(8));
    send(8'hC3, 8'h5A, 8'h96, 8'hFF, 1'b0);
    send(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
    send(8'h69, 8'h00, 8'hF0, 8'h00, 1'b0);
    wait_drained();

    configure(OrderGrb, tick_t'(15'h5555), tick_t'(15'h2AAA), tick_t'(15'h2AAA),
              tick_t'(15'h5555));
    send(8'h0F, 8'hF0, 8'h3C, 8'hAA, 1'b0);
    send(8'hFF, 8'h00, 8'h81, 8'h00, 1'b1);
    wait_drained();

    // random phases of frames: runs of pixels ending in a last mark, some
    // stray marks, and frames cut off at a phase end
    sent       = 0;
    phase      = 0;
    frame_left = 0;
    while (sent < RandomItems) begin
      configure(color_order_e'($urandom_range(0, 3)), random_duration(),
                random_duration(), random_duration(), random_duration());
      if (phase == 1) hold_off_req++;
      phase_items = $urandom_range(12, 20);
      repeat (phase_items) begin
        if (frame_left == 0) frame_left = $urandom_range(1, 6);
        frame_left--;
        px.red        = random_byte();
        px.green      = random_byte();
        px.blue       = random_byte();
        px.white      = random_byte();
        px.last_pixel = (frame_left == 0) || ($urandom_range(0, 9) == 0);
        send_pixel(px);
        sent++;
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      wait_drained();
      phase++;
    end

    repeat (EndSettle) @(posedge clk);
    if (mismatch_cnt == 0 && symbols_due == 0) begin
      $display("** led_pixel_bit_encoder_unit: PASSED **");
    end else begin
      $display("** led_pixel_bit_encoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
